FILE: hw/rtl/reca_pkg.sv
// ----------------------------------------------------------------------------
// reca_pkg: shared types and constants of the random core allocator
// Default sizes, register indexes, operation codes, controller states and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package reca_pkg;

  // Default sizing
  localparam int MAX_CORES_DEF  = 32;
  localparam int CONTAINERS_DEF = 16;

  // Core numbering: cores below FIRST_CORE are reserved
  localparam int FIRST_CORE = 2;
  localparam int MIN_CORES  = 3;

  // Configuration port
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_CORES_W = 6;
  localparam logic [CFG_CORES_W-1:0] CORES_RESET = 6'd32;
  localparam logic [CFG_DATA_W-1:0]  SEED_RESET  = 32'd1;

  // Random generator: Galois LFSR, shift right
  localparam int               LFSR_W    = 32;
  localparam logic [LFSR_W-1:0] LFSR_MASK = 32'hD000_0001;

  // Remainder unit: dividend bits retired per cycle
  localparam int RADIX_BITS = 4;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CORES_IN_USE = 1'b0,
    CFG_RANDOM_SEED  = 1'b1
  } reca_cfg_e;

  // Operation codes
  typedef enum logic {
    OP_START = 1'b0,
    OP_EXIT  = 1'b1
  } reca_op_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_DECIDE,
    ST_MOD,
    ST_WRITE
  } reca_state_e;

  // Controller -> datapath
  typedef struct packed {
    logic load;   // latch event, update running set
    logic scan;   // one step of the running-list build
    logic read;   // read owner of current core
    logic draw;   // advance LFSR, start remainder
    logic write;  // commit owner, emit result
  } reca_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic need_draw;
    logic mod_done;
    logic last_core;
  } reca_sts_t;

endpackage

FILE: hw/rtl/random_equipartition_core_allocator_core.sv
// ----------------------------------------------------------------------------
// random_equipartition_core_allocator_core: random core allocator, top level
// Start and exit events of job containers; after each event reports the
// owner of every managed core from core 2 upward.
// ----------------------------------------------------------------------------
//  channel  | signals                                      | handshake
//  ---------+----------------------------------------------+---------------------
//  event    | operation_i, container_i                     | start && !busy
//  result   | core_index_o, owner_o, status_o, last_o      | result_strobe_o
//  config   | cfg_index_i, cfg_data_i                      | cfg_valid_i/ready_o
//
//  One event first builds the list of running containers, then reads,
//  decides and writes each core in turn, with a random draw through the
//  iterative remainder unit (4 bits per cycle over the 32-bit draw) when
//  one is taken. A start event draws for every core, and busy stays up
//  until the last result has left the output register. An exit event
//  draws only for the cores it frees.
//  Reset sets every core unowned, nothing running, LFSR to the seed.
//  Results come one per strobe cycle; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module random_equipartition_core_allocator_core
  import reca_pkg::*;
#(
  parameter int MAX_CORES  = MAX_CORES_DEF,
  parameter int CONTAINERS = CONTAINERS_DEF,
  localparam int CoreW = $clog2(MAX_CORES),
  localparam int CtrW  = (CONTAINERS > 1) ? $clog2(CONTAINERS) : 1,
  localparam int OwnW  = $clog2(CONTAINERS + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // event
  input  logic                  start,
  output logic                  busy,
  input  logic                  operation_i,
  input  logic [CtrW-1:0]       container_i,
  // results
  output logic                  result_strobe_o,
  output logic [CoreW-1:0]      core_index_o,
  output logic [OwnW-1:0]       owner_o,
  output logic                  status_o,
  output logic                  last_o
);

  reca_cmd_t cmd;
  reca_sts_t sts;
  logic      ctrl_busy;

  // Busy until the last result has left the output register
  assign busy        = ctrl_busy | result_strobe_o;
  assign cfg_ready_o = 1'b1;

  reca_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (start && !busy),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (ctrl_busy)
  );

  reca_dp #(
    .MAX_CORES  (MAX_CORES),
    .CONTAINERS (CONTAINERS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .operation_i     (operation_i),
    .container_i     (container_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .result_strobe_o (result_strobe_o),
    .core_index_o    (core_index_o),
    .owner_o         (owner_o),
    .status_o        (status_o),
    .last_o          (last_o)
  );

endmodule

FILE: hw/rtl/reca_mod.sv
// ----------------------------------------------------------------------------
// reca_mod: iterative remainder unit
// Computes a 32-bit dividend modulo a small divisor, RADIX_BITS dividend bits
// per cycle by restoring compare and subtract.
// ----------------------------------------------------------------------------
module reca_mod
  import reca_pkg::*;
#(
  parameter int DIV_W = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [LFSR_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] rem_o
);

  localparam int STEPS  = LFSR_W / RADIX_BITS;
  localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic [LFSR_W-1:0] dvd_q, dvd_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  div_q;
  logic [STEP_W-1:0] step_q;
  logic              run_q;

  // One step: shift in RADIX_BITS dividend bits, reduce after each
  always_comb begin
    logic [DIV_W:0] t;
    rem_d = rem_q;
    dvd_d = dvd_q;
    for (int j = 0; j < RADIX_BITS; j++) begin
      t = {rem_d, dvd_d[LFSR_W-1]};
      dvd_d = {dvd_d[LFSR_W-2:0], 1'b0};
      if (t >= {1'b0, div_q}) begin
        t = t - {1'b0, div_q};
      end
      rem_d = t[DIV_W-1:0];
    end
  end

  // Control of the iteration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      step_q <= '0;
    end else if (run_q) begin
      step_q <= step_q + STEP_W'(1);
      if (step_q == STEP_W'(STEPS - 1)) begin
        run_q <= 1'b0;
      end
    end
  end

  // Operands and partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (run_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = run_q && (step_q == STEP_W'(STEPS - 1));
  assign rem_o  = rem_q;

endmodule

FILE: hw/rtl/reca_dp.sv
// ----------------------------------------------------------------------------
// reca_dp: allocator datapath
// Holds configuration, LFSR, running set, the ordered list of running
// containers, the core owner memory and the result register.
// ----------------------------------------------------------------------------
module reca_dp
  import reca_pkg::*;
#(
  parameter int MAX_CORES  = MAX_CORES_DEF,
  parameter int CONTAINERS = CONTAINERS_DEF,
  localparam int CoreW = $clog2(MAX_CORES),
  localparam int CtrW  = (CONTAINERS > 1) ? $clog2(CONTAINERS) : 1,
  localparam int OwnW  = $clog2(CONTAINERS + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // event
  input  logic                  operation_i,
  input  logic [CtrW-1:0]       container_i,
  // control
  input  reca_cmd_t             cmd_i,
  output reca_sts_t             sts_o,
  // results
  output logic                  result_strobe_o,
  output logic [CoreW-1:0]      core_index_o,
  output logic [OwnW-1:0]       owner_o,
  output logic                  status_o,
  output logic                  last_o
);

  localparam int NW   = $clog2(MAX_CORES + 1);
  localparam int CntW = OwnW;
  localparam logic [OwnW-1:0] NO_OWNER = OwnW'(CONTAINERS);

  // Configuration and generator
  logic [CFG_CORES_W-1:0] cores_q;
  logic [LFSR_W-1:0]      lfsr_q, lfsr_nxt;

  // Event context
  reca_op_e           op_q;
  logic [CtrW-1:0]    ctr_q;
  logic               ctr_ok_q;
  logic [NW-1:0]      n_q, n_d;
  logic [CONTAINERS-1:0] running_q;

  // Running-list build
  logic [CtrW-1:0]    scan_q;
  logic [CntW-1:0]    cnt_q;
  logic [CtrW-1:0]    list_q [CONTAINERS];

  // Core walk and owner memory
  logic [CoreW-1:0]   core_q;
  logic [OwnW-1:0]    owner_mem [MAX_CORES];
  logic [MAX_CORES-1:0] valid_q;
  logic [OwnW-1:0]    rd_own_q;
  logic               rd_vld_q;
  logic [OwnW-1:0]    own_cur, own_new;
  logic               hit, fail;

  // Remainder unit
  logic               mod_done;
  logic [CntW-1:0]    rem;

  // Output register
  logic               out_vld_q;
  logic [CoreW-1:0]   out_core_q;
  logic [OwnW-1:0]    out_own_q;
  logic               out_fail_q;
  logic               out_last_q;

  // Galois LFSR step
  assign lfsr_nxt = {1'b0, lfsr_q[LFSR_W-1:1]} ^ (lfsr_q[0] ? LFSR_MASK : '0);

  // Effective core count, clamped
  always_comb begin
    if (cores_q < CFG_CORES_W'(MIN_CORES)) begin
      n_d = NW'(MIN_CORES);
    end else if ({1'b0, cores_q} > (CFG_CORES_W + 1)'(MAX_CORES)) begin
      n_d = NW'(MAX_CORES);
    end else begin
      n_d = NW'(cores_q);
    end
  end

  // Config, LFSR; the user must write config only while idle (not enforced)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cores_q <= CORES_RESET;
      lfsr_q  <= SEED_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CORES_IN_USE: cores_q <= cfg_data_i[CFG_CORES_W-1:0];
        CFG_RANDOM_SEED:  lfsr_q  <= (cfg_data_i == '0) ? LFSR_W'(1) : cfg_data_i;
        default: ;
      endcase
    end else if (cmd_i.draw) begin
      lfsr_q <= lfsr_nxt;
    end
  end

  // Running set
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= '0;
    end else if (cmd_i.load && (CtrW'(container_i) < CtrW'(CONTAINERS) ||
                                CONTAINERS == (1 << CtrW))) begin
      running_q[container_i] <= (operation_i == OP_START);
    end
  end

  // Event context, list build and core counter
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= reca_op_e'(operation_i);
      ctr_q    <= container_i;
      ctr_ok_q <= (CtrW'(container_i) < CtrW'(CONTAINERS)) ||
                  (CONTAINERS == (1 << CtrW));
      n_q      <= n_d;
      scan_q   <= '0;
      cnt_q    <= '0;
      core_q   <= CoreW'(FIRST_CORE);
    end else begin
      if (cmd_i.scan) begin
        scan_q <= scan_q + CtrW'(1);
        if (running_q[scan_q]) begin
          list_q[cnt_q[CtrW-1:0]] <= scan_q;
          cnt_q <= cnt_q + CntW'(1);
        end
      end
      if (cmd_i.write) begin
        core_q <= core_q + CoreW'(1);
      end
    end
  end

  // Owner memory, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      rd_own_q <= owner_mem[core_q];
    end
    if (cmd_i.write) begin
      owner_mem[core_q] <= own_new;
    end
  end

  // Written flags; an unwritten core reads as unowned
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.read) begin
        rd_vld_q <= valid_q[core_q];
      end
      if (cmd_i.write) begin
        valid_q[core_q] <= 1'b1;
      end
    end
  end

  reca_mod #(
    .DIV_W (CntW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.draw),
    .dividend_i (lfsr_nxt),
    .divisor_i  (cnt_q),
    .done_o     (mod_done),
    .rem_o      (rem)
  );

  // Per-core decision
  assign own_cur = rd_vld_q ? rd_own_q : NO_OWNER;
  assign hit     = (own_cur == OwnW'(ctr_q));
  assign fail    = ctr_ok_q && (op_q == OP_EXIT) && hit && (cnt_q == '0);

  always_comb begin
    own_new = own_cur;
    if (ctr_ok_q) begin
      case (op_q)
        OP_START: begin
          if (rem == '0) begin
            own_new = OwnW'(ctr_q);
          end else if (hit) begin
            own_new = NO_OWNER;
          end
        end
        OP_EXIT: begin
          if (hit) begin
            own_new = (cnt_q == '0) ? NO_OWNER : OwnW'(list_q[rem[CtrW-1:0]]);
          end
        end
        default: own_new = own_cur;
      endcase
    end
  end

  // Status to controller
  assign sts_o.scan_done = (scan_q == CtrW'(CONTAINERS - 1));
  assign sts_o.need_draw = ctr_ok_q && ((op_q == OP_START) || (hit && (cnt_q != '0)));
  assign sts_o.mod_done  = mod_done;
  assign sts_o.last_core = ((NW'(core_q) + NW'(1)) == n_q);

  // Result register: one-cycle strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= cmd_i.write;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      out_core_q <= core_q;
      out_own_q  <= own_new;
      out_fail_q <= fail;
      out_last_q <= sts_o.last_core;
    end
  end

  assign result_strobe_o = out_vld_q;
  assign core_index_o    = out_core_q;
  assign owner_o         = out_own_q;
  assign status_o        = out_fail_q;
  assign last_o          = out_last_q;

endmodule

FILE: hw/rtl/reca_ctrl.sv
// ----------------------------------------------------------------------------
// reca_ctrl: allocator controller
// Sequences one event: running-list build, then read, optional draw and
// remainder, and write for every managed core.
// ----------------------------------------------------------------------------
module reca_ctrl
  import reca_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  reca_sts_t sts_i,
  output reca_cmd_t cmd_o,
  output logic      busy_o
);

  reca_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (accept_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts_i.need_draw) begin
          cmd_o.draw = 1'b1;
          state_d    = ST_MOD;
        end else begin
          state_d = ST_WRITE;
        end
      end
      ST_MOD: begin
        if (sts_i.mod_done) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd_o.write = 1'b1;
        state_d     = sts_i.last_core ? ST_IDLE : ST_READ;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/reca_checker.sv
// ----------------------------------------------------------------------------
// reca_checker: port-level checks of the allocator
// Result strobes only while busy, event framing, no reserved cores reported
// and failed-core ownership.
module reca_checker
  import reca_pkg::*;
#(
  parameter int MAX_CORES  = MAX_CORES_DEF,
  parameter int CONTAINERS = CONTAINERS_DEF,
  localparam int CoreW = $clog2(MAX_CORES),
  localparam int OwnW  = $clog2(CONTAINERS + 1)
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             result_strobe_o,
  input logic [CoreW-1:0] core_index_o,
  input logic [OwnW-1:0]  owner_o,
  input logic             status_o,
  input logic             last_o
);

  // Results appear only inside a transaction
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> busy)
    else $error("result strobe while not busy");

  // An accepted event makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("event accepted but block not busy");

  // Last result ends the transaction
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && last_o |=> !busy)
    else $error("still busy after last result");

  // Reserved cores are never reported
  a_core_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> core_index_o >= CoreW'(FIRST_CORE))
    else $error("reserved core reported");

  // A core that found no receiver is unowned
  a_fail_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && status_o |-> owner_o == OwnW'(CONTAINERS))
    else $error("failed core reported with an owner");

endmodule

bind random_equipartition_core_allocator_core reca_checker #(
  .MAX_CORES  (MAX_CORES),
  .CONTAINERS (CONTAINERS)
) u_reca_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .result_strobe_o (result_strobe_o),
  .core_index_o    (core_index_o),
  .owner_o         (owner_o),
  .status_o        (status_o),
  .last_o          (last_o)
);

FILE: bench/random_equipartition_core_allocator_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// random_equipartition_core_allocator_core_tb: core allocator testbench
// Drives job start and exit events and register writes, and keeps a model of
// the core ownership table, running set and LFSR. Every reported core is
// checked against that model in order.
// ----------------------------------------------------------------------------
module random_equipartition_core_allocator_core_tb;
  import reca_pkg::*;

  localparam int         NumCtr    = CONTAINERS_DEF;
  localparam int         NumCores  = MAX_CORES_DEF;
  localparam logic [4:0] NoOwner   = 5'(CONTAINERS_DEF);
  localparam int         SettleCyc = 16;
  localparam int         StallMax  = 2000;

  // one reported core
  typedef struct packed {
    logic [4:0] core;
    logic [4:0] owner;
    logic       status;
    logic       last;
  } core_report_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  start;
  logic                  busy;
  logic                  operation_i;
  logic [3:0]            container_i;
  logic                  result_strobe_o;
  logic [4:0]            core_index_o;
  logic [4:0]            owner_o;
  logic                  status_o;
  logic                  last_o;

  // allocator model state
  logic [4:0]            owner_tbl [NumCores];
  logic [NumCtr-1:0]     running_set;
  logic [31:0]           lfsr_state;
  logic [5:0]            cores_reg;
  core_report_t          core_report_q[$];

  // stimulus-side view of which containers are running
  logic [NumCtr-1:0]     live_ctrs;
  int unsigned           gap_pct;
  int unsigned           err_cnt;
  int unsigned           stall_cnt;

  random_equipartition_core_allocator_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .start           (start),
    .busy            (busy),
    .operation_i     (operation_i),
    .container_i     (container_i),
    .result_strobe_o (result_strobe_o),
    .core_index_o    (core_index_o),
    .owner_o         (owner_o),
    .status_o        (status_o),
    .last_o          (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Model
  // ---------------------------------------------------------------------------

  function automatic void reset_model();
    int i;
    for (i = 0; i < NumCores; i++) owner_tbl[i] = NoOwner;
    running_set = '0;
    cores_reg   = CORES_RESET;
    lfsr_state  = SEED_RESET;
  endfunction

  // Galois LFSR, shift right; the new value is the draw
  function automatic logic [31:0] next_draw();
    logic shifted_out;
    shifted_out = lfsr_state[0];
    lfsr_state  = lfsr_state >> 1;
    if (shifted_out) lfsr_state = lfsr_state ^ LFSR_MASK;
    return lfsr_state;
  endfunction

  // k-th running container, counted from container 0
  function automatic logic [4:0] kth_running(int unsigned k);
    int c;
    int unsigned seen;
    seen = 0;
    for (c = 0; c < NumCtr; c++) begin
      if (running_set[c]) begin
        if (seen == k) return 5'(c);
        seen++;
      end
    end
    return NoOwner;
  endfunction

  function automatic void apply_reg_write(reca_cfg_e idx, logic [31:0] data);
    if (idx == CFG_CORES_IN_USE) begin
      cores_reg = data[5:0];
    end else begin
      lfsr_state = (data == '0) ? 32'd1 : data;
    end
  endfunction

  // update ownership for one event and queue the per-core report
  function automatic void allocate_event(reca_op_e op, logic [3:0] ctr);
    int unsigned  n;
    int unsigned  cnt;
    int           i;
    logic         freed_fail [NumCores];
    core_report_t rpt;
    n = cores_reg;
    if (n < MIN_CORES) n = MIN_CORES;
    if (n > NumCores) n = NumCores;
    for (i = 0; i < NumCores; i++) freed_fail[i] = 1'b0;
    if (op == OP_START) begin
      running_set[ctr] = 1'b1;
      cnt = $countones(running_set);
      for (i = FIRST_CORE; i < n; i++) begin
        if (next_draw() % cnt == 0) owner_tbl[i] = {1'b0, ctr};
        else if (owner_tbl[i] == {1'b0, ctr}) owner_tbl[i] = NoOwner;
      end
    end else begin
      running_set[ctr] = 1'b0;
      cnt = $countones(running_set);
      for (i = FIRST_CORE; i < n; i++) begin
        if (owner_tbl[i] == {1'b0, ctr}) begin
          if (cnt == 0) begin
            owner_tbl[i]  = NoOwner;
            freed_fail[i] = 1'b1;
          end else begin
            owner_tbl[i] = kth_running(next_draw() % cnt);
          end
        end
      end
    end
    for (i = FIRST_CORE; i < n; i++) begin
      rpt.core   = 5'(i);
      rpt.owner  = owner_tbl[i];
      rpt.status = freed_fail[i];
      rpt.last   = (i + 1 == n);
      core_report_q.push_back(rpt);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: follows handshakes, checks reports, watchdog
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin
    core_report_t want;
    if (!rst_ni) begin
      reset_model();
      stall_cnt <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) apply_reg_write(reca_cfg_e'(cfg_index_i), cfg_data_i);
      if (start && !busy) allocate_event(reca_op_e'(operation_i), container_i);
      if (result_strobe_o) begin
        if (core_report_q.size() == 0) begin
          $display("%0t: unexpected result, core_index %0d owner %0d status %0d last %0d",
                   $time, core_index_o, owner_o, status_o, last_o);
          err_cnt++;
        end else begin
          want = core_report_q.pop_front();
          check_field("core_index", want.core, core_index_o);
          check_field("owner", want.owner, owner_o);
          check_field("status", want.status, status_o);
          check_field("last", want.last, last_o);
        end
      end
      if (result_strobe_o || (start && !busy) || (cfg_valid_i && cfg_ready_o)) begin
        stall_cnt <= 0;
      end else if (stall_cnt >= StallMax) begin
        $display("%0t: watchdog expired, no transaction for %0d cycles", $time, StallMax);
        $display("TB_ERROR");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver tasks
  // ---------------------------------------------------------------------------

  // one event transaction, with a random lead-in gap
  task automatic send_event(reca_op_e op, logic [3:0] ctr);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start       <= 1'b1;
    operation_i <= op;
    container_i <= ctr;
    do @(posedge clk_i); while (busy);
    live_ctrs[ctr] = (op == OP_START);
  endtask

  // drop start and let the block finish and all reports drain
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (busy || core_report_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_reg(reca_cfg_e idx, logic [31:0] data);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // core count in the low six bits, upper bits are don't care
  task automatic write_cores(logic [5:0] cores);
    write_reg(CFG_CORES_IN_USE, {26'($urandom), cores});
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // default settings: single job, restart, exits of idle and last jobs
  task automatic test_basic_events();
    gap_pct = 0;
    send_event(OP_EXIT, 4'd5);
    send_event(OP_START, 4'd7);
    send_event(OP_EXIT, 4'd7);
    send_event(OP_START, 4'd0);
    send_event(OP_START, 4'd15);
    send_event(OP_START, 4'd15);
    send_event(OP_EXIT, 4'd3);
    send_event(OP_START, 4'd10);
    send_event(OP_EXIT, 4'd0);
    send_event(OP_EXIT, 4'd15);
    send_event(OP_EXIT, 4'd10);
  endtask

  // core count clamping at both ends
  task automatic test_core_counts();
    logic [5:0] counts [7];
    int i;
    counts = '{6'd0, 6'd2, 6'd3, 6'd4, 6'd63, 6'd33, 6'd32};
    gap_pct = 21;
    for (i = 0; i < 7; i++) begin
      write_cores(counts[i]);
      send_event(OP_START, 4'(i + 1));
      send_event(OP_START, 4'(i + 8));
    end
  endtask

  // seed zero, all ones, and reload while jobs are running
  task automatic test_seeds();
    gap_pct = 21;
    write_reg(CFG_RANDOM_SEED, 32'h0);
    send_event(OP_START, 4'd2);
    send_event(OP_EXIT, 4'd1);
    write_reg(CFG_RANDOM_SEED, 32'hFFFF_FFFF);
    send_event(OP_START, 4'd4);
    send_event(OP_EXIT, 4'd8);
    write_reg(CFG_RANDOM_SEED, $urandom);
    send_event(OP_EXIT, 4'd2);
  endtask

  // mostly starts of idle jobs and exits of running ones, some noise
  task automatic random_events(int count);
    int          i;
    int unsigned roll;
    logic [3:0]  ctr;
    reca_op_e    op;
    for (i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll >= 90) begin
        op  = reca_op_e'($urandom_range(1));
        ctr = 4'($urandom_range(NumCtr - 1));
      end else if (live_ctrs == '0 || roll < 45) begin
        op  = OP_START;
        ctr = 4'($urandom_range(NumCtr - 1));
        if (roll < 35 && live_ctrs != '1) begin
          while (live_ctrs[ctr]) ctr = 4'($urandom_range(NumCtr - 1));
        end
      end else begin
        op = OP_EXIT;
        do ctr = 4'($urandom_range(NumCtr - 1)); while (!live_ctrs[ctr]);
      end
      send_event(op, ctr);
    end
  endtask

  task automatic test_random_phases();
    int phase;
    for (phase = 0; phase < 5; phase++) begin
      gap_pct = (phase == 2) ? 0 : 21;
      if (phase == 4) write_cores(6'd32);
      else write_cores(6'($urandom_range(MIN_CORES, NumCores)));
      write_reg(CFG_RANDOM_SEED, $urandom);
      random_events(40);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_CORES_IN_USE;
    cfg_data_i  = '0;
    start       = 1'b0;
    operation_i = OP_START;
    container_i = '0;
    live_ctrs   = '0;
    gap_pct     = 0;
    err_cnt     = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_events();
    test_core_counts();
    test_seeds();
    test_random_phases();

    wait_idle();
    if (core_report_q.size() != 0) begin
      $display("%0t: %0d core reports never arrived", $time, core_report_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
